@@ rtl/core/ctb_pkg.sv @@
// Shared constants and types for the clipped transparent blitter.
package ctb_pkg;

  localparam int MAX_DIM = 256;
  localparam int POS_W   = $clog2(MAX_DIM);
  localparam int DIM_W   = POS_W + 1;
  localparam int CODE_W  = 8;
  localparam int GLYPH_W = 8;
  localparam int ADDR_W  = 16;
  localparam int OCODE_W = 7;

  localparam int IN_TDATA_W  = CODE_W + GLYPH_W;
  localparam int OUT_FIELD_W = ADDR_W + OCODE_W + GLYPH_W;
  localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DST_WIDTH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DST_HEIGHT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_X_OFFSET   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_Y_OFFSET   = 3'd5;

  typedef struct packed {
    logic [DIM_W-1:0] sw;
    logic [DIM_W-1:0] sh;
    logic [DIM_W-1:0] dw;
    logic [DIM_W-1:0] dh;
    logic [POS_W-1:0] xo;
    logic [POS_W-1:0] yo;
    logic             frame_ok;
  } cfg_t;

  typedef struct packed {
    logic [CODE_W-1:0]  code;
    logic [GLYPH_W-1:0] glyph;
    logic [POS_W-1:0]   col;
    logic [POS_W-1:0]   row;
  } item_t;

endpackage

@@ rtl/core/ctb_cfg_regs.sv @@
// Configuration register file with size clamping and frame range check.
module ctb_cfg_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [ctb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ctb_pkg::DIM_W-1:0]     cfg_wdata,
  output ctb_pkg::cfg_t                 cfg
);
  import ctb_pkg::*;

  logic [DIM_W-1:0] src_w_r, src_h_r, dst_w_r, dst_h_r, x_off_r, y_off_r;
  logic [DIM_W-1:0] dw_c, dh_c;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_w_r <= DIM_W'(1);
      src_h_r <= DIM_W'(1);
      dst_w_r <= DIM_W'(1);
      dst_h_r <= DIM_W'(1);
      x_off_r <= '0;
      y_off_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SRC_WIDTH:  src_w_r <= cfg_wdata;
        REG_SRC_HEIGHT: src_h_r <= cfg_wdata;
        REG_DST_WIDTH:  dst_w_r <= cfg_wdata;
        REG_DST_HEIGHT: dst_h_r <= cfg_wdata;
        REG_X_OFFSET:   x_off_r <= cfg_wdata;
        REG_Y_OFFSET:   y_off_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                 input logic zero_as_one);
    logic [DIM_W-1:0] r;
    if (v == '0 && zero_as_one) r = DIM_W'(1);
    else if (v > DIM_W'(MAX_DIM)) r = DIM_W'(MAX_DIM);
    else r = v;
    return r;
  endfunction

  assign dw_c = clamp_dim(dst_w_r, 1'b0);
  assign dh_c = clamp_dim(dst_h_r, 1'b0);

  assign cfg.sw = clamp_dim(src_w_r, 1'b1);
  assign cfg.sh = clamp_dim(src_h_r, 1'b1);
  assign cfg.dw = dw_c;
  assign cfg.dh = dh_c;
  assign cfg.xo = x_off_r[POS_W-1:0];
  assign cfg.yo = y_off_r[POS_W-1:0];
  assign cfg.frame_ok = !x_off_r[DIM_W-1] && (x_off_r < dw_c) &&
                        !y_off_r[DIM_W-1] && (y_off_r < dh_c);

endmodule

@@ rtl/core/ctb_pos_ctr.sv @@
// Source column and row counter, wrapping at the source size.
module ctb_pos_ctr (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      adv,
  input  logic [ctb_pkg::DIM_W-1:0] sw,
  input  logic [ctb_pkg::DIM_W-1:0] sh,
  output logic [ctb_pkg::POS_W-1:0] col,
  output logic [ctb_pkg::POS_W-1:0] row
);
  import ctb_pkg::*;

  logic [POS_W-1:0] col_r, col_nxt, row_r, row_nxt;
  logic [DIM_W-1:0] col_inc, row_inc;

  assign col_inc = {1'b0, col_r} + DIM_W'(1);
  assign row_inc = {1'b0, row_r} + DIM_W'(1);

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (adv) begin
      if (col_inc >= sw) begin
        col_nxt = '0;
        row_nxt = (row_inc >= sh) ? '0 : row_inc[POS_W-1:0];
      end else begin
        col_nxt = col_inc[POS_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  assign col = col_r;
  assign row = row_r;

endmodule

@@ rtl/core/ctb_clip_stage.sv @@
// Clip, color key and address compute feeding the result register.
module ctb_clip_stage (
  input  logic                            clk,
  input  logic                            rst_n,
  input  ctb_pkg::cfg_t                   cfg,
  input  ctb_pkg::item_t                  item,
  input  logic                            item_vld,
  output logic                            item_rdy,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [ctb_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import ctb_pkg::*;

  localparam int MUL_W = POS_W + DIM_W + 1;

  logic [DIM_W-1:0]   dx, dy;
  logic [MUL_W-1:0]   addr_full;
  logic               opaque, in_src, hit;
  logic               vld_r;
  logic [ADDR_W-1:0]  addr_r;
  logic [OCODE_W-1:0] code_r;
  logic [GLYPH_W-1:0] glyph_r;

  assign dx = {1'b0, cfg.xo} + {1'b0, item.col};
  assign dy = {1'b0, cfg.yo} + {1'b0, item.row};

  assign opaque = !item.code[CODE_W-1] && (item.code != '0);
  assign in_src = ({1'b0, item.col} < cfg.sw) && ({1'b0, item.row} < cfg.sh);
  assign hit    = cfg.frame_ok && in_src && opaque && (dx < cfg.dw) && (dy < cfg.dh);

  assign addr_full = MUL_W'(dy[POS_W-1:0]) * MUL_W'(cfg.dw) + MUL_W'(dx);

  assign item_rdy = !vld_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (item_rdy) begin
      vld_r <= item_vld && hit;
    end
  end

  always_ff @(posedge clk) begin
    if (item_vld && item_rdy) begin
      addr_r  <= ADDR_W'(addr_full);
      code_r  <= item.code[OCODE_W-1:0];
      glyph_r <= item.glyph;
    end
  end

  assign out_tvalid = vld_r;
  assign out_tdata  = OUT_TDATA_W'({glyph_r, code_r, addr_r});

endmodule

@@ rtl/core/clipped_transparent_blitter.sv @@
// Top level of the clipped transparent blitter.
//
// Source cells enter on the in_ stream, one beat per cell in raster order
// over the whole source frame; the block tracks column and row itself.
// Each opaque cell (color code 1 to 127) that lands inside the
// destination, clipped at its right and bottom edges, leaves as one beat on
// the out_ stream carrying the linear destination address, color and glyph.
// Transparent or clipped cells produce no beat. An offset that is negative
// or at/past the destination size suppresses the whole frame.
// Registers are written through cfg_we/cfg_index/cfg_wdata; the user must write
// them only while idle, as the block itself does not enforce it. An input
// register and a result register lie between the streams. Throughput: one
// cell per cycle while out_tready is high; clip, key and address multiply-add
// sit in one stage. Reset clears the position to the top-left cell, the sizes
// to 1 and the offsets to 0. When out_tready is low the result holds and the
// input register still fills; in_tready drops only when both registers are full.
module clipped_transparent_blitter (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [ctb_pkg::IN_TDATA_W-1:0]  in_tdata,   // color_code, glyph
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [ctb_pkg::OUT_TDATA_W-1:0] out_tdata,  // write_address, out_color_code, out_glyph
  input  logic                            cfg_we,
  input  logic [ctb_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ctb_pkg::DIM_W-1:0]       cfg_wdata
);
  import ctb_pkg::*;

  cfg_t             cfg;
  item_t            s1_r;
  logic             s1_vld_r;
  logic             s2_rdy;
  logic             in_beat;
  logic [POS_W-1:0] col, row;

  ctb_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  ctb_pos_ctr u_pos (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (in_beat),
    .sw    (cfg.sw),
    .sh    (cfg.sh),
    .col   (col),
    .row   (row)
  );

  assign in_tready = !s1_vld_r || s2_rdy;
  assign in_beat   = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_tready) begin
      s1_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_beat) begin
      s1_r.code  <= in_tdata[CODE_W-1:0];
      s1_r.glyph <= in_tdata[CODE_W +: GLYPH_W];
      s1_r.col   <= col;
      s1_r.row   <= row;
    end
  end

  ctb_clip_stage u_clip (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .item       (s1_r),
    .item_vld   (s1_vld_r),
    .item_rdy   (s2_rdy),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> s1_vld_r && out_tvalid && !out_tready)
    else $error("input stalled while a stage had room");

  a_result_from_stage: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(s1_vld_r))
    else $error("result beat without a staged cell");

  a_opaque_only: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[ADDR_W +: OCODE_W] != '0)
    else $error("transparent cell emitted");

  a_stage_fill: assert property (@(posedge clk) disable iff (!rst_n)
    in_beat |=> s1_vld_r)
    else $error("accepted beat lost before the stage register");

endmodule

@@ tb/blit_checker.sv @@
// Blit checker: predicts destination writes from observed cells and compares them.
`timescale 1ns / 1ps

module blit_checker import ctb_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  input  logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // color_code, glyph
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic [OUT_TDATA_W-1:0] out_tdata,  // write_address, out_color_code, out_glyph
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [DIM_W-1:0]       cfg_wdata,
  output int unsigned            errors,
  output int unsigned            outstanding
);

  typedef struct packed {
    logic [ADDR_W-1:0]  addr;
    logic [OCODE_W-1:0] code;
    logic [GLYPH_W-1:0] glyph;
  } cell_write_t;

  logic [DIM_W-1:0] src_w, src_h, dst_w, dst_h, x_off, y_off;
  logic [POS_W-1:0] col, row;
  cell_write_t      pending_writes[$];

  function automatic int fit_dim(input logic [DIM_W-1:0] v, input bit zero_as_one);
    if (v == '0 && zero_as_one) return 1;
    if (v > MAX_DIM) return MAX_DIM;
    return int'(v);
  endfunction

  task automatic report(input string field, input int unsigned got, input int unsigned want);
    $display("%0t: mismatch on %s: got 0x%0h, want 0x%0h", $time, field, got, want);
    errors++;
  endtask

  task automatic blit_cell(input logic [CODE_W-1:0] code, input logic [GLYPH_W-1:0] glyph);
    int sw, sh, dw, dh, xo, yo, c, r, dx, dy;
    cell_write_t w;
    sw = fit_dim(src_w, 1'b1);
    sh = fit_dim(src_h, 1'b1);
    dw = fit_dim(dst_w, 1'b0);
    dh = fit_dim(dst_h, 1'b0);
    xo = int'($signed(x_off));
    yo = int'($signed(y_off));
    c  = int'(col);
    r  = int'(row);
    dx = xo + c;
    dy = yo + r;
    if (xo >= 0 && xo < dw && yo >= 0 && yo < dh && c < sw && r < sh &&
        !code[CODE_W-1] && code != '0 && dx < dw && dy < dh) begin
      w.addr  = ADDR_W'(dy * dw + dx);
      w.code  = code[OCODE_W-1:0];
      w.glyph = glyph;
      pending_writes.push_back(w);
    end
    if (c + 1 >= sw) begin
      col = '0;
      row = (r + 1 >= sh) ? '0 : POS_W'(r + 1);
    end else begin
      col = POS_W'(c + 1);
    end
  endtask

  always @(posedge clk) begin
    cell_write_t got, want;
    if (!rst_n) begin
      src_w  = DIM_W'(1);
      src_h  = DIM_W'(1);
      dst_w  = DIM_W'(1);
      dst_h  = DIM_W'(1);
      x_off  = '0;
      y_off  = '0;
      col    = '0;
      row    = '0;
      errors = 0;
      pending_writes.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        got.addr  = out_tdata[ADDR_W-1:0];
        got.code  = out_tdata[ADDR_W +: OCODE_W];
        got.glyph = out_tdata[ADDR_W+OCODE_W +: GLYPH_W];
        if (pending_writes.size() == 0) begin
          report("write_address with no write pending", 32'(got.addr), 0);
        end else begin
          want = pending_writes.pop_front();
          if (got.addr != want.addr)
            report("write_address", 32'(got.addr), 32'(want.addr));
          if (got.code != want.code)
            report("out_color_code", 32'(got.code), 32'(want.code));
          if (got.glyph != want.glyph)
            report("out_glyph", 32'(got.glyph), 32'(want.glyph));
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_SRC_WIDTH:  src_w = cfg_wdata;
          REG_SRC_HEIGHT: src_h = cfg_wdata;
          REG_DST_WIDTH:  dst_w = cfg_wdata;
          REG_DST_HEIGHT: dst_h = cfg_wdata;
          REG_X_OFFSET:   x_off = cfg_wdata;
          REG_Y_OFFSET:   y_off = cfg_wdata;
          default: ;
        endcase
      end
      if (in_tvalid && in_tready)
        blit_cell(in_tdata[CODE_W-1:0], in_tdata[CODE_W +: GLYPH_W]);
    end
    outstanding <= pending_writes.size();
  end

endmodule

@@ tb/tb.sv @@
// Testbench top: drives cells and register writes into the blitter and gives the verdict.
`timescale 1ns / 1ps

module tb import ctb_pkg::*; ();

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;
  localparam int HOLD_CYCLES    = 300;
  localparam int SETTLE_CYCLES  = 4;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int CELL_TARGET    = 1300;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;   // color_code, glyph
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;  // write_address, out_color_code, out_glyph
  logic                   cfg_we;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [DIM_W-1:0]       cfg_wdata;
  int unsigned            errors;
  int unsigned            outstanding;

  bit calm        = 1'b0;
  int hold_token  = 0;
  int idle_cycles = 0;

  clipped_transparent_blitter uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  blit_checker writes_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .errors      (errors),
    .outstanding (outstanding)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [CODE_W-1:0] rand_code();
    if ($urandom_range(0, 99) < 65) return CODE_W'($urandom_range(1, 127));
    return CODE_W'($urandom_range(0, 255));
  endfunction

  function automatic logic [DIM_W-1:0] pick_dim(input int hi);
    int r;
    r = $urandom_range(0, 99);
    if (r < 4) return '0;
    if (r < 8) return DIM_W'($urandom_range(257, 511));
    if (r < 12) return DIM_W'(MAX_DIM);
    return DIM_W'($urandom_range(1, hi));
  endfunction

  function automatic logic [DIM_W-1:0] pick_offset(input logic [DIM_W-1:0] dim);
    int lim, r;
    lim = (dim > MAX_DIM) ? MAX_DIM : dim;
    r = $urandom_range(0, 99);
    if (r < 75 && lim > 0) return DIM_W'($urandom_range(0, lim - 1));
    if (r < 85) return DIM_W'($urandom_range(256, 511));
    if (r < 92) return DIM_W'(lim);
    return DIM_W'($urandom_range(0, 511));
  endfunction

  task automatic send_cell(input logic [CODE_W-1:0] code, input logic [GLYPH_W-1:0] glyph);
    int gap;
    in_tvalid <= 1'b1;
    in_tdata  <= {glyph, code};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    gap = idle_len();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_random(input int n);
    repeat (n) send_cell(rand_code(), GLYPH_W'($urandom_range(0, 255)));
  endtask

  task automatic send_opaque(input int n);
    repeat (n) send_cell(CODE_W'($urandom_range(1, 127)), GLYPH_W'($urandom_range(0, 255)));
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  task automatic setup(input logic [DIM_W-1:0] sw, sh, dw, dh, xo, yo);
    drain();
    write_reg(REG_SRC_WIDTH, sw);
    write_reg(REG_SRC_HEIGHT, sh);
    write_reg(REG_DST_WIDTH, dw);
    write_reg(REG_DST_HEIGHT, dh);
    write_reg(REG_X_OFFSET, xo);
    write_reg(REG_Y_OFFSET, yo);
    case ($urandom_range(0, 5))
      0: write_reg(REG_SPARE_A, DIM_W'($urandom_range(0, 511)));
      1: write_reg(REG_SPARE_B, DIM_W'($urandom_range(0, 511)));
      default: ;
    endcase
    cfg_we <= 1'b0;
  endtask

  task automatic random_setup();
    logic [DIM_W-1:0] dw, dh;
    dw = pick_dim(24);
    dh = pick_dim(24);
    setup(pick_dim(12), pick_dim(12), dw, dh, pick_offset(dw), pick_offset(dh));
  endtask

  // receiver: random stalls, plus one long hold-off on request
  initial begin : sink
    int stall_left;
    int holds_seen;
    stall_left = 0;
    holds_seen = 0;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_token != holds_seen) begin
        holds_seen = hold_token;
        stall_left = HOLD_CYCLES;
      end
      if (stall_left > 0) begin
        out_tready <= 1'b0;
        stall_left--;
      end else begin
        out_tready <= 1'b1;
        stall_left = idle_len();
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    int sent;
    int n;
    sent = 0;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= '0;
    cfg_wdata <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // reset sizes: every code class at cell zero
    send_cell(8'h01, 8'h00);
    send_cell(8'h7F, 8'hFF);
    send_cell(8'h00, 8'h5A);
    send_cell(8'hFF, 8'hA5);
    send_cell(8'h80, 8'h3C);
    // zero source size, top address corner
    setup(0, 0, 256, 256, 255, 255);
    send_cell(8'h7F, 8'hAA);
    // clip at right and bottom edges
    setup(3, 2, 4, 3, 2, 2);
    send_opaque(6);
    // negative and out-of-range offsets, zero destination
    setup(1, 1, 8, 8, 9'h1FF, 0);
    send_opaque(1);
    setup(1, 1, 8, 8, 0, 9'h100);
    send_opaque(1);
    setup(1, 1, 8, 8, 8, 0);
    send_opaque(1);
    setup(1, 1, 0, 8, 0, 0);
    send_opaque(1);
    // oversized sizes clamp
    setup(511, 300, 257, 2, 0, 1);
    send_opaque(1);
    // shrink the source under the current position
    setup(10, 2, 16, 4, 0, 0);
    send_opaque(6);
    setup(3, 2, 16, 4, 0, 0);
    send_opaque(3);

    // back-pressure: hold the receiver while cells keep coming
    setup(8, 8, 16, 16, 4, 4);
    calm = 1'b1;
    hold_token++;
    send_opaque(64);
    sent = 64;

    while (sent < CELL_TARGET) begin
      calm = ($urandom_range(0, 4) == 0);
      random_setup();
      n = $urandom_range(10, 90);
      send_random(n);
      sent += n;
    end

    calm = 1'b0;
    drain();
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

@@ clipped_transparent_blitter.f @@
rtl/core/ctb_pkg.sv
rtl/core/ctb_cfg_regs.sv
rtl/core/ctb_pos_ctr.sv
rtl/core/ctb_clip_stage.sv
rtl/core/clipped_transparent_blitter.sv
tb/blit_checker.sv
tb/tb.sv
